// ===== hdl/glb_pkg.sv =====
// ----------------------------------------------------------------------------
// glb_pkg
// Shared types and constants of the greedy line breaker: wrap modes, record
// kinds, register indexes, reset values and the request and record layouts.
// ----------------------------------------------------------------------------
package glb_pkg;

	typedef enum logic [1:0] {
		MODE_NOWRAP = 2'd0,
		MODE_WORD   = 2'd1,
		MODE_CHAR   = 2'd2,
		MODE_UNUSED = 2'd3
	} wrap_mode_t;

	typedef enum logic [1:0] {
		KIND_LINE  = 2'd0,
		KIND_FINAL = 2'd1,
		KIND_END   = 2'd2
	} record_kind_t;

	typedef enum logic [1:0] {
		REG_WRAP_MODE = 2'd0,
		REG_MAX_WIDTH = 2'd1,
		REG_MAX_LINES = 2'd2
	} cfg_index_t;

	localparam int unsigned CfgDataW = 16;

	localparam wrap_mode_t   WrapModeReset = MODE_WORD;
	localparam logic [15:0]  MaxWidthReset = 16'd128;
	localparam logic [7:0]   MaxLinesReset = 8'd8;
	localparam logic [15:0]  Sat16         = 16'hFFFF;

	typedef struct packed {
		logic       end_of_text;
		logic [7:0] char_width;
		logic [2:0] char_bytes;
		logic       is_newline;
		logic       is_breakable;
		logic       is_invalid;
	} char_req_t;

	typedef struct packed {
		record_kind_t record_kind;
		logic [15:0]  start_offset;
		logic [15:0]  byte_length;
		logic [15:0]  pixel_width;
		logic [15:0]  char_count;
		logic [7:0]   lines_so_far;
	} line_rec_t;

	typedef struct packed {
		wrap_mode_t  wrap_mode;
		logic [15:0] max_width;
		logic [7:0]  max_lines;
	} glb_cfg_t;

endpackage

// ===== hdl/glb_chan_if.sv =====
// ----------------------------------------------------------------------------
// glb_chan_if
// Valid/ready channel carrying one request or record per transfer.
// ----------------------------------------------------------------------------
interface glb_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/glb_core.sv =====
// ----------------------------------------------------------------------------
// glb_core
// Line state and its update: consumes one request per step and
// produces at most one line record.
// ----------------------------------------------------------------------------
module glb_core (
	input  logic               clk,
	input  logic               arst_n,
	input  glb_pkg::glb_cfg_t  cfg,
	input  logic               step,
	input  glb_pkg::char_req_t req,
	output logic               res_valid,
	output glb_pkg::line_rec_t res
);
	import glb_pkg::*;

	logic [15:0] bpos_q, start_q, width_q, chars_q, bytes_q;
	logic [15:0] brk_byte_q, brk_width_q, brk_chars_q;
	logic        have_brk_q, halted_q;
	logic [7:0]  count_q;

	logic [15:0] bpos_d, start_d, width_d, chars_d, bytes_d;
	logic [15:0] brk_byte_d, brk_width_d, brk_chars_d;
	logic        have_brk_d, halted_d;
	logic [7:0]  count_d;

	logic        nl, brk, pending, overflow, cnt_ok, halt_emit;
	logic [16:0] over_sum, wsum;
	logic [7:0]  cnt_emit;
	logic [15:0] base_start, base_w, base_c;
	logic        emit_req;
	logic [15:0] emit_start, emit_len, emit_w, emit_c;

	assign nl        = req.is_newline & ~req.is_invalid;
	assign brk       = req.is_breakable & ~req.is_invalid;
	assign over_sum  = {1'b0, width_q} + {9'b0, req.char_width};
	assign overflow  = (over_sum > {1'b0, cfg.max_width}) && (chars_q != '0);
	assign cnt_ok    = count_q < cfg.max_lines;
	assign cnt_emit  = count_q + 8'd1;
	assign halt_emit = (cnt_ok ? cnt_emit : count_q) >= cfg.max_lines;
	assign pending   = (cfg.wrap_mode == MODE_NOWRAP) || (chars_q != '0);

	always_comb begin
		bpos_d      = bpos_q;
		start_d     = start_q;
		width_d     = width_q;
		chars_d     = chars_q;
		bytes_d     = bytes_q;
		brk_byte_d  = brk_byte_q;
		brk_width_d = brk_width_q;
		brk_chars_d = brk_chars_q;
		have_brk_d  = have_brk_q;
		halted_d    = halted_q;
		count_d     = count_q;
		res_valid   = 1'b0;
		res         = '{record_kind: KIND_END, lines_so_far: count_q, default: '0};
		emit_req    = 1'b0;
		emit_start  = start_q;
		emit_len    = bytes_q;
		emit_w      = width_q;
		emit_c      = chars_q;
		base_start  = start_q;
		base_w      = width_q;
		base_c      = chars_q;
		wsum        = '0;

		if (step && req.end_of_text) begin
			// end of text: one record always, then clear the text state
			res_valid = 1'b1;
			if (cfg.wrap_mode != MODE_UNUSED && !halted_q && pending && cnt_ok) begin
				res = '{record_kind: KIND_FINAL, start_offset: start_q,
					byte_length: bytes_q, pixel_width: width_q,
					char_count: chars_q, lines_so_far: cnt_emit};
			end
			bpos_d      = '0;
			start_d     = '0;
			width_d     = '0;
			chars_d     = '0;
			bytes_d     = '0;
			brk_byte_d  = '0;
			brk_width_d = '0;
			brk_chars_d = '0;
			have_brk_d  = 1'b0;
			halted_d    = 1'b0;
			count_d     = '0;
		end else if (step) begin
			bpos_d = bpos_q + {13'b0, req.char_bytes};
			if (!halted_q && cfg.wrap_mode != MODE_UNUSED) begin
				if (cfg.wrap_mode == MODE_NOWRAP) begin
					if (nl) begin
						emit_req = 1'b1;
						halted_d = 1'b1;
					end else begin
						bytes_d = bpos_d - start_q;
						if (!req.is_invalid) begin
							width_d = over_sum[16] ? Sat16 : over_sum[15:0];
							chars_d = (chars_q == Sat16) ? Sat16 : chars_q + 16'd1;
						end
					end
				end else if (nl) begin
					emit_req   = 1'b1;
					start_d    = bpos_d;
					width_d    = '0;
					chars_d    = '0;
					bytes_d    = '0;
					have_brk_d = 1'b0;
				end else begin
					if (overflow) begin
						emit_req   = 1'b1;
						have_brk_d = 1'b0;
						if (cfg.wrap_mode == MODE_WORD && have_brk_q) begin
							emit_len   = brk_byte_q - start_q;
							emit_w     = brk_width_q;
							emit_c     = brk_chars_q;
							base_start = brk_byte_q;
							base_w     = width_q - brk_width_q;
							base_c     = chars_q - brk_chars_q;
						end else begin
							base_start = bpos_q;
							base_w     = '0;
							base_c     = '0;
						end
					end
					start_d = base_start;
					width_d = base_w;
					chars_d = base_c;
					// halt on the emitted line: skip adding this character
					if (!(overflow && halt_emit)) begin
						wsum    = {1'b0, base_w} + {9'b0, req.char_width};
						width_d = wsum[16] ? Sat16 : wsum[15:0];
						chars_d = (base_c == Sat16) ? Sat16 : base_c + 16'd1;
						bytes_d = bpos_d - base_start;
						if (cfg.wrap_mode == MODE_WORD && brk) begin
							brk_byte_d  = bpos_d;
							brk_width_d = width_d;
							brk_chars_d = chars_d;
							have_brk_d  = 1'b1;
						end
					end
				end
			end
			if (emit_req) begin
				if (cnt_ok) begin
					res_valid = 1'b1;
					count_d   = cnt_emit;
					res = '{record_kind: KIND_LINE, start_offset: emit_start,
						byte_length: emit_len, pixel_width: emit_w,
						char_count: emit_c, lines_so_far: cnt_emit};
				end
				if (halt_emit) begin
					halted_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q      <= '0;
			start_q     <= '0;
			width_q     <= '0;
			chars_q     <= '0;
			bytes_q     <= '0;
			brk_byte_q  <= '0;
			brk_width_q <= '0;
			brk_chars_q <= '0;
			have_brk_q  <= 1'b0;
			halted_q    <= 1'b0;
			count_q     <= '0;
		end else begin
			bpos_q      <= bpos_d;
			start_q     <= start_d;
			width_q     <= width_d;
			chars_q     <= chars_d;
			bytes_q     <= bytes_d;
			brk_byte_q  <= brk_byte_d;
			brk_width_q <= brk_width_d;
			brk_chars_q <= brk_chars_d;
			have_brk_q  <= have_brk_d;
			halted_q    <= halted_d;
			count_q     <= count_d;
		end
	end

	// an end item always leaves the counter and halt flag cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && req.end_of_text |=> count_q == '0 && !halted_q && chars_q == '0)
		else $error("text state not cleared after end item");

	// a line record always moves the line counter up by one
	a_line_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.record_kind == KIND_LINE |=> count_q == $past(count_q) + 8'd1)
		else $error("line record without counter advance");

	// no character work while halted except the byte position
	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && step && !req.end_of_text |=> $stable(width_q) && $stable(count_q))
		else $error("line state changed while halted");

endmodule

// ===== hdl/greedy_line_breaker_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_line_breaker_unit
// Splits a stream of decoded characters into display lines (no-wrap, word
// and character wrap modes) and emits one record per finished line, up to max_lines, and one at end of text.
// Pipeline: an accepted request passes through the input register, then the
// result register. Throughput: one request per cycle while the record
// side takes results.
// Reset: arst_n clears the line state and both stage valids and restores
// wrap_mode = word, max_width = 128, max_lines = 8.
// ----------------------------------------------------------------------------
module greedy_line_breaker_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	glb_chan_if.sink                          in_ch,
	glb_chan_if.source                        out_ch,
	input  logic                              cfg_we,
	input  glb_pkg::cfg_index_t               cfg_index,
	input  logic [glb_pkg::CfgDataW-1:0]      cfg_data
);
	import glb_pkg::*;

	// configuration registers
	glb_cfg_t cfg_q;

	// stage 1: registered request
	logic      valid_s1;
	char_req_t req_s1;

	// stage 2: registered result record
	logic      out_valid_q;
	line_rec_t out_rec_q;

	logic      advance;
	logic      core_valid;
	line_rec_t core_rec;

	// Advance stage 1 whenever the result register is empty or being drained;
	// a request that yields no record still needs the slot free this cycle.
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_rec_q;

	// Take register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap_mode <= WrapModeReset;
			cfg_q.max_width <= MaxWidthReset;
			cfg_q.max_lines <= MaxLinesReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WRAP_MODE: cfg_q.wrap_mode <= wrap_mode_t'(cfg_data[1:0]);
				REG_MAX_WIDTH: cfg_q.max_width <= cfg_data[15:0];
				REG_MAX_LINES: cfg_q.max_lines <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Hold the request in stage 1 until the core can consume it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_s1 <= in_ch.data;
		end
	end

	glb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (advance),
		.req       (req_s1),
		.res_valid (core_valid),
		.res       (core_rec)
	);

	// Load the result register on advance; otherwise drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			out_rec_q <= core_rec;
		end
	end

	// an end request that advances always yields a record next cycle
	a_end_gives_record: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.end_of_text |=> out_valid_q && out_rec_q.record_kind != KIND_LINE)
		else $error("end request produced no final record");

	// a stalled stage-1 request stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stage 1 request lost while stalled");

	// line records always carry a nonzero line number
	a_line_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rec_q.record_kind != KIND_END |-> out_rec_q.lines_so_far != '0)
		else $error("line record with zero line number");

	// an untaken record is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_rec_q))
		else $error("pending record overwritten");

endmodule
